/* src/dlsq_pkg.sv */
// Package for the delta-list sleep queue: types, codes and defaults.
package dlsq_pkg;

  localparam int SLOTS_DEF          = 16;
  localparam int THREAD_ID_BITS_DEF = 8;
  localparam int DELAY_BITS_DEF     = 32;
  localparam int MAX_RESULTS        = 16;

  localparam int IN_ID_W   = 8;
  localparam int IN_TIME_W = 32;
  localparam int OUT_ID_W  = 8;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_RELEASED = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FIX,
    ST_PLACE,
    ST_FULL,
    ST_TICK_HEAD,
    ST_REL
  } state_t;

  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic [OUT_ID_W-1:0] tid;
    logic                last;
  } emit_t;

endpackage

/* src/dlsq_mem.sv */
// Entry memory: one write port, one read port with registered read data.
module dlsq_mem #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 40,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/dlsq_ctrl.sv */
// Sequencer: sorted insert with shift, head tick and release walk over the entry memory.
module dlsq_ctrl
  import dlsq_pkg::*;
#(
  parameter int SLOTS          = SLOTS_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF,
  parameter int DELAY_BITS     = DELAY_BITS_DEF,
  parameter int IDX_W          = $clog2(SLOTS),
  parameter int WORD_W         = THREAD_ID_BITS + DELAY_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [IN_ID_W-1:0]   in_tid,
  input  logic [IN_TIME_W-1:0] in_time,
  output emit_t                emit,
  input  logic                 emit_taken,
  output logic                 mem_re,
  output logic [IDX_W-1:0]     mem_raddr,
  input  logic [WORD_W-1:0]    mem_rdata,
  output logic                 mem_we,
  output logic [IDX_W-1:0]     mem_waddr,
  output logic [WORD_W-1:0]    mem_wdata
);

  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int ID_EXT_W  = (THREAD_ID_BITS > OUT_ID_W) ? THREAD_ID_BITS : OUT_ID_W;
  localparam int DLY_EXT_W = (DELAY_BITS > IN_TIME_W) ? DELAY_BITS : IN_TIME_W;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] l);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(l);
    if (s >= (CNT_W+1)'(SLOTS)) begin
      s = s - (CNT_W+1)'(SLOTS);
    end
    return s[IDX_W-1:0];
  endfunction

  state_t                    state_r, state_nxt;
  logic [IDX_W-1:0]          head_r, head_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          pos_r, pos_nxt;
  logic [DELAY_BITS-1:0]     rest_r, rest_nxt;
  logic [THREAD_ID_BITS-1:0] new_id_r, new_id_nxt;
  logic [WORD_W-1:0]         succ_r, succ_nxt;
  logic [CNT_W-1:0]          sh_r, sh_nxt;
  logic                      pend_r, pend_nxt;
  logic [CNT_W-1:0]          pend_dst_r, pend_dst_nxt;
  logic [THREAD_ID_BITS-1:0] cur_id_r, cur_id_nxt;
  logic [CNT_W-1:0]          rel_n_r, rel_n_nxt;

  logic                      accept;
  logic                      full;
  logic [DLY_EXT_W-1:0]      time_ext;
  logic [DELAY_BITS-1:0]     time_in;
  logic [ID_EXT_W-1:0]       id_in_ext;
  logic [ID_EXT_W-1:0]       cur_id_ext;
  logic [THREAD_ID_BITS-1:0] rd_id;
  logic [DELAY_BITS-1:0]     rd_delta;
  logic [DELAY_BITS-1:0]     head_dec;
  logic                      scan_le;
  logic [CNT_W:0]            pos1, rel1, rel2, cnt_w1;
  logic                      next_rel;

  assign accept     = in_valid && in_ready;
  assign full       = (count_r == CNT_W'(SLOTS));
  assign time_ext   = DLY_EXT_W'(in_time);
  assign time_in    = time_ext[DELAY_BITS-1:0];
  assign id_in_ext  = ID_EXT_W'(in_tid);
  assign cur_id_ext = ID_EXT_W'(cur_id_r);
  assign rd_id      = mem_rdata[WORD_W-1:DELAY_BITS];
  assign rd_delta   = mem_rdata[DELAY_BITS-1:0];
  assign head_dec   = (rd_delta == '0) ? '0 : rd_delta - DELAY_BITS'(1);
  assign scan_le    = (rd_delta <= rest_r);
  assign pos1       = (CNT_W+1)'(pos_r) + (CNT_W+1)'(1);
  assign rel1       = (CNT_W+1)'(rel_n_r) + (CNT_W+1)'(1);
  assign rel2       = (CNT_W+1)'(rel_n_r) + (CNT_W+1)'(2);
  assign cnt_w1     = (CNT_W+1)'(count_r);
  assign next_rel   = (rel1 < cnt_w1) && (32'(rel1) < 32'(MAX_RESULTS)) && (rd_delta == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode) begin
            state_nxt = (count_r == '0) ? ST_IDLE : ST_TICK_HEAD;
          end else if (full) begin
            state_nxt = ST_FULL;
          end else if (count_r == '0) begin
            state_nxt = ST_PLACE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!scan_le) begin
          state_nxt = ST_SHIFT;
        end else if (pos1 == cnt_w1) begin
          state_nxt = ST_PLACE;
        end
      end
      ST_SHIFT: begin
        if ((CNT_W+1)'(sh_r) <= pos1) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: state_nxt = ST_PLACE;
      ST_PLACE: begin
        if (emit_taken) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FULL: begin
        if (emit_taken) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TICK_HEAD: state_nxt = (head_dec != '0) ? ST_IDLE : ST_REL;
      ST_REL: begin
        if (emit_taken && !next_rel) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    emit      = '{valid: 1'b0, kind: KIND_ACCEPTED, tid: '0, last: 1'b1};
    mem_re    = 1'b0;
    mem_raddr = head_r;
    mem_we    = 1'b0;
    mem_waddr = head_r;
    mem_wdata = succ_r;
    case (state_r)
      ST_IDLE: begin
        mem_re = accept && !(in_mode == 1'b0 && full) && (count_r != '0);
      end
      ST_SCAN: begin
        mem_re    = scan_le && (pos1 != cnt_w1);
        mem_raddr = phys(head_r, pos1[CNT_W-1:0]);
      end
      ST_SHIFT: begin
        mem_we    = pend_r;
        mem_waddr = phys(head_r, pend_dst_r);
        mem_wdata = mem_rdata;
        mem_re    = ((CNT_W+1)'(sh_r) > pos1);
        mem_raddr = phys(head_r, sh_r - CNT_W'(1));
      end
      ST_FIX: begin
        mem_we    = 1'b1;
        mem_waddr = phys(head_r, pos1[CNT_W-1:0]);
        mem_wdata = succ_r;
      end
      ST_PLACE: begin
        emit.valid = 1'b1;
        emit.kind  = KIND_ACCEPTED;
        mem_we     = emit_taken;
        mem_waddr  = phys(head_r, pos_r);
        mem_wdata  = {new_id_r, rest_r};
      end
      ST_FULL: begin
        emit.valid = 1'b1;
        emit.kind  = KIND_FULL;
      end
      ST_TICK_HEAD: begin
        mem_we    = (head_dec != '0);
        mem_waddr = head_r;
        mem_wdata = {rd_id, head_dec};
        mem_re    = (count_r > CNT_W'(1)) && (head_dec == '0);
        mem_raddr = phys(head_r, CNT_W'(1));
      end
      ST_REL: begin
        emit.valid = 1'b1;
        emit.kind  = KIND_RELEASED;
        emit.tid   = cur_id_ext[OUT_ID_W-1:0];
        emit.last  = !next_rel;
        mem_re     = emit_taken && next_rel && (rel2 < cnt_w1);
        mem_raddr  = phys(head_r, rel2[CNT_W-1:0]);
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    rest_nxt     = rest_r;
    new_id_nxt   = new_id_r;
    succ_nxt     = succ_r;
    sh_nxt       = sh_r;
    pend_nxt     = pend_r;
    pend_dst_nxt = pend_dst_r;
    cur_id_nxt   = cur_id_r;
    rel_n_nxt    = rel_n_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pos_nxt    = '0;
          new_id_nxt = id_in_ext[THREAD_ID_BITS-1:0];
          rest_nxt   = (time_in == '0) ? DELAY_BITS'(1) : time_in;
        end
      end
      ST_SCAN: begin
        if (scan_le) begin
          rest_nxt = rest_r - rd_delta;
          pos_nxt  = pos1[CNT_W-1:0];
        end else begin
          succ_nxt = {rd_id, rd_delta - rest_r};
          sh_nxt   = count_r;
          pend_nxt = 1'b0;
        end
      end
      ST_SHIFT: begin
        if ((CNT_W+1)'(sh_r) > pos1) begin
          pend_nxt     = 1'b1;
          pend_dst_nxt = sh_r;
          sh_nxt       = sh_r - CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
      end
      ST_PLACE: begin
        if (emit_taken) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ST_TICK_HEAD: begin
        cur_id_nxt = rd_id;
        rel_n_nxt  = '0;
      end
      ST_REL: begin
        if (emit_taken) begin
          if (next_rel) begin
            cur_id_nxt = rd_id;
            rel_n_nxt  = rel1[CNT_W-1:0];
          end else begin
            head_nxt  = phys(head_r, rel1[CNT_W-1:0]);
            count_nxt = count_r - rel1[CNT_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    rest_r     <= rest_nxt;
    new_id_r   <= new_id_nxt;
    succ_r     <= succ_nxt;
    sh_r       <= sh_nxt;
    pend_dst_r <= pend_dst_nxt;
    cur_id_r   <= cur_id_nxt;
    rel_n_r    <= rel_n_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOTS))
    else $error("entry count above capacity");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FULL && emit_taken) |=> $stable(count_r))
    else $error("rejected sleep changed the entry count");

  a_place_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PLACE && emit_taken) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("accepted sleep did not add one entry");

  a_rel_more: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REL && emit.valid && !emit.last) |-> (rel1 < cnt_w1))
    else $error("non-final release without a following entry");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !mem_we)
    else $error("memory written during the search");

endmodule

/* src/delta_list_sleep_queue_unit.sv */
// Sleep timer queue top level: sequencer, entry memory and output register.
// Sleep: a search reads entries from the head to find the position (skipped on an empty
//   queue); entries behind it shift up one slot, their delta is fixed, the new entry is written.
// Tick: none on an empty queue; else decrements the head, then releases zero-delta entries.
// One transaction at a time; results leave through a one-entry output register.
// Reset (rst_n low, synchronous) empties the queue; memory contents are not cleared.
module delta_list_sleep_queue_unit
  import dlsq_pkg::*;
#(
  parameter int SLOTS          = SLOTS_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF,
  parameter int DELAY_BITS     = DELAY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] thread_id, [39:8] sleep_time
  input  logic [0:0]  in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] released_thread
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int WORD_W = THREAD_ID_BITS + DELAY_BITS;

  emit_t               emit;
  logic                emit_taken;
  logic                mem_re, mem_we;
  logic [IDX_W-1:0]    mem_raddr, mem_waddr;
  logic [WORD_W-1:0]   mem_rdata, mem_wdata;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_kind_r;
  logic [OUT_ID_W-1:0] out_tid_r;
  logic                out_last_r;

  assign emit_taken = emit.valid && (!out_valid_r || out_tready);

  dlsq_ctrl #(
    .SLOTS          (SLOTS),
    .THREAD_ID_BITS (THREAD_ID_BITS),
    .DELAY_BITS     (DELAY_BITS),
    .IDX_W          (IDX_W),
    .WORD_W         (WORD_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_mode    (in_tuser[0]),
    .in_tid     (in_tdata[7:0]),
    .in_time    (in_tdata[39:8]),
    .emit       (emit),
    .emit_taken (emit_taken),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata)
  );

  dlsq_mem #(
    .DEPTH  (SLOTS),
    .WIDTH  (WORD_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_taken) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_taken) begin
      out_kind_r <= emit.kind;
      out_tid_r  <= emit.tid;
      out_last_r <= emit.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
